// ===== design/nec_tx_pkg.sv =====
`default_nettype none

package nec_tx_pkg;

  localparam int unsigned TICK_COUNT_WIDTH = 16;
  localparam int unsigned CMP_WIDTH = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_cnt_t;
  typedef logic [CMP_WIDTH-1:0] cmp_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEADER = 3'd1,
    PH_ADDR   = 3'd2,
    PH_NADDR  = 3'd3,
    PH_DATA   = 3'd4,
    PH_NDATA  = 3'd5
  } phase_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ADDRESS     = 3'd0,
    CFG_SECOND_ADDR = 3'd1,
    CFG_LEADER_MARK = 3'd2,
    CFG_LEADER_TOT  = 3'd3,
    CFG_BIT_MARK    = 3'd4,
    CFG_ZERO_TOT    = 3'd5,
    CFG_ONE_TOT     = 3'd6
  } cfg_idx_e;

  localparam logic [7:0] ADDRESS_RESET = 8'h5a;
  localparam logic [7:0] SECOND_ADDR_RESET = 8'ha5;
  localparam logic [15:0] LEADER_MARK_RESET = 16'd900;
  localparam logic [15:0] LEADER_TOT_RESET = 16'd1350;
  localparam logic [15:0] BIT_MARK_RESET = 16'd56;
  localparam logic [15:0] ZERO_TOT_RESET = 16'd112;
  localparam logic [15:0] ONE_TOT_RESET = 16'd225;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== design/nec_tx_core.sv =====
`default_nettype none

module nec_tx_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [nec_tx_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [nec_tx_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata_i,
  input  logic                                    step_i,
  input  logic                                    operation_i,
  input  logic [7:0]                              payload_i,
  output nec_tx_pkg::result_t                     result_o
);
  import nec_tx_pkg::*;

  logic [7:0]  address_q;
  logic [7:0]  second_addr_q;
  logic [15:0] leader_mark_q;
  logic [15:0] leader_tot_q;
  logic [15:0] bit_mark_q;
  logic [15:0] zero_tot_q;
  logic [15:0] one_tot_q;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  tick_cnt_t  cnt_q, cnt_d;
  logic [7:0] held_q, held_d;
  logic       carrier_q, carrier_d;
  logic       sending_q, sending_d;

  tick_cnt_t  cnt_inc;
  cmp_t       cnt_ext;
  logic [7:0] cur_byte;
  logic       cur_bit;
  logic [15:0] bit_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q     <= ADDRESS_RESET;
      second_addr_q <= SECOND_ADDR_RESET;
      leader_mark_q <= LEADER_MARK_RESET;
      leader_tot_q  <= LEADER_TOT_RESET;
      bit_mark_q    <= BIT_MARK_RESET;
      zero_tot_q    <= ZERO_TOT_RESET;
      one_tot_q     <= ONE_TOT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDRESS:     address_q     <= cfg_wdata_i[7:0];
        CFG_SECOND_ADDR: second_addr_q <= cfg_wdata_i[7:0];
        CFG_LEADER_MARK: leader_mark_q <= cfg_wdata_i;
        CFG_LEADER_TOT:  leader_tot_q  <= cfg_wdata_i;
        CFG_BIT_MARK:    bit_mark_q    <= cfg_wdata_i;
        CFG_ZERO_TOT:    zero_tot_q    <= cfg_wdata_i;
        CFG_ONE_TOT:     one_tot_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_ext = CMP_WIDTH'(cnt_inc);

  always_comb begin
    unique case (phase_q)
      PH_ADDR:  cur_byte = address_q;
      PH_NADDR: cur_byte = second_addr_q;
      PH_DATA:  cur_byte = held_q;
      default:  cur_byte = ~held_q;
    endcase
  end

  assign cur_bit   = cur_byte[bit_idx_q[2:0]];
  assign bit_total = cur_bit ? one_tot_q : zero_tot_q;

  always_comb begin
    phase_d   = phase_q;
    bit_idx_d = bit_idx_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    carrier_d = carrier_q;
    sending_d = sending_q;
    if (step_i) begin
      if (operation_i) begin
        held_d    = payload_i;
        phase_d   = PH_LEADER;
        cnt_d     = '0;
        bit_idx_d = '0;
        sending_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_LEADER: begin
            cnt_d     = cnt_inc;
            sending_d = 1'b1;
            if (cnt_ext < CMP_WIDTH'(leader_mark_q)) begin
              carrier_d = 1'b1;
            end else if (cnt_ext < CMP_WIDTH'(leader_tot_q)) begin
              carrier_d = 1'b0;
            end else begin
              phase_d   = PH_ADDR;
              cnt_d     = '0;
              bit_idx_d = '0;
            end
          end
          PH_ADDR, PH_NADDR, PH_DATA, PH_NDATA: begin
            cnt_d = cnt_inc;
            if (bit_idx_q[3]) begin
              cnt_d     = '0;
              bit_idx_d = '0;
              unique case (phase_q)
                PH_ADDR:  phase_d = PH_NADDR;
                PH_NADDR: phase_d = PH_DATA;
                PH_DATA:  phase_d = PH_NDATA;
                default: begin
                  phase_d   = PH_IDLE;
                  sending_d = 1'b0;
                end
              endcase
            end else if (cnt_ext <= CMP_WIDTH'(bit_mark_q)) begin
              carrier_d = 1'b1;
            end else if (cnt_ext <= CMP_WIDTH'(bit_total)) begin
              carrier_d = 1'b0;
            end else begin
              bit_idx_d = bit_idx_q + 4'd1;
              cnt_d     = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_idx_q <= '0;
      cnt_q     <= '0;
      held_q    <= '0;
      carrier_q <= 1'b0;
      sending_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      bit_idx_q <= bit_idx_d;
      cnt_q     <= cnt_d;
      held_q    <= held_d;
      carrier_q <= carrier_d;
      sending_q <= sending_d;
    end
  end

  assign result_o.carrier_on = carrier_d;
  assign result_o.busy_res   = sending_d;

endmodule

`default_nettype wire

// ===== design/nec_ir_frame_transmitter.sv =====
// NEC-style IR frame transmitter, stepped by tick items.
// The input channel (in_valid_i / in_ready_o) carries one item per transfer:
// operation_i low is one timer tick, high starts a frame with payload_i as
// the data byte. Every input transfer yields exactly one result transfer on
// the output channel (out_valid_o / out_ready_i) giving the carrier level
// and the busy flag after that item.
// The result is registered at the edge that accepts the item. Throughput
// is one item per cycle while in_ready_o is high, set by the state update
// of the frame sequencer.
// A two-entry output buffer (result register plus skid register) lets an
// item be accepted while an earlier result still waits; in_ready_o drops
// only when both entries are full, and rises again once the receiver takes
// a result.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
// next edge; the user must make them while the block is idle (not enforced).
// Reset clears the sequencer to idle with the carrier off, restores the
// register defaults and empties the output buffer.
`default_nettype none

module nec_ir_frame_transmitter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nec_tx_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [nec_tx_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic [7:0]                            payload_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  carrier_on_o,
  output logic                                  busy_res_o
);
  import nec_tx_pkg::*;

  logic    accept;
  logic    take;
  result_t new_res;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = out_valid_q && out_ready_i;

  nec_tx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (accept),
    .operation_i (operation_i),
    .payload_i   (payload_i),
    .result_o    (new_res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_d       = new_res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = new_res;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_valid_q;
  assign carrier_on_o = out_q.carrier_on;
  assign busy_res_o   = out_q.busy_res;

endmodule

`default_nettype wire
